### hdl/acrd_pkg.sv
// Shared types, constants and functions for the AES counter random draw engine.
`default_nettype none
package acrd_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned BlockW = 128;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned ModW   = 6;
  localparam int unsigned DigitW = 8;

  localparam logic [CmdW-1:0] CmdWord     = 3'd0;
  localparam logic [CmdW-1:0] CmdByte     = 3'd1;
  localparam logic [CmdW-1:0] CmdBit      = 3'd2;
  localparam logic [CmdW-1:0] CmdPrime    = 3'd3;
  localparam logic [CmdW-1:0] CmdPrimeNz  = 3'd4;
  localparam logic [CmdW-1:0] CmdWordNot1 = 3'd5;
  localparam logic [CmdW-1:0] CmdModN     = 3'd6;

  localparam logic [0:0] RegKeyLow  = 1'b0;
  localparam logic [0:0] RegKeyHigh = 1'b1;

  // request from the draw sequencer to the cipher
  typedef struct packed {
    logic        start;
    logic [31:0] ctr;
  } aes_req_t;

  typedef struct packed {
    logic              done;
    logic [BlockW-1:0] block;
  } aes_rsp_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

### hdl/acrd_aes_core.sv
// Round-iterative AES-128 encryption of a counter block, key expanded on the fly.
`default_nettype none
module acrd_aes_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [acrd_pkg::KeyW-1:0] key_low_i,
  input  wire logic [acrd_pkg::KeyW-1:0] key_high_i,
  input  wire acrd_pkg::aes_req_t        req_i,
  output acrd_pkg::aes_rsp_t             rsp_o
);

  logic [7:0] st_q [16];
  logic [7:0] st_d [16];
  logic [7:0] rk_q [16];
  logic [7:0] rk_d [16];
  logic [7:0] rcon_q, rcon_d;
  logic [3:0] round_q, round_d;
  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] kin [16];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      kin[i]   = key_low_i[8*i +: 8];
      kin[i+8] = key_high_i[8*i +: 8];
    end
    // next round key from current
    rk_d[0] = rk_q[0] ^ acrd_pkg::sbox(rk_q[13]) ^ rcon_q;
    rk_d[1] = rk_q[1] ^ acrd_pkg::sbox(rk_q[14]);
    rk_d[2] = rk_q[2] ^ acrd_pkg::sbox(rk_q[15]);
    rk_d[3] = rk_q[3] ^ acrd_pkg::sbox(rk_q[12]);
    for (int i = 4; i < 16; i++) rk_d[i] = rk_q[i] ^ rk_d[i-4];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) t[c*4+i] = acrd_pkg::sbox(st_q[((c+i)%4)*4+i]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        m[c*4+i] = t[c*4+i] ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3]
                 ^ acrd_pkg::xt(t[c*4+i] ^ t[c*4+((i+1)%4)]);
      end
    end
    st_d    = st_q;
    round_d = round_q;
    busy_d  = busy_q;
    rcon_d  = rcon_q;
    done_d  = 1'b0;
    if (req_i.start && !busy_q) begin
      for (int i = 0; i < 16; i++) st_d[i] = req_i.ctr[8*(i%4) +: 8] ^ kin[i];
      round_d = 4'd1;
      busy_d  = 1'b1;
      rcon_d  = 8'h01;
    end else if (busy_q) begin
      for (int i = 0; i < 16; i++)
        st_d[i] = ((round_q == 4'd10) ? t[i] : m[i]) ^ rk_d[i];
      rcon_d  = acrd_pkg::xt(rcon_q);
      round_d = round_q + 4'd1;
      if (round_q == 4'd10) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
      rcon_q  <= 8'h01;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      round_q <= round_d;
      rcon_q  <= rcon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (req_i.start && !busy_q) rk_q <= kin;
    else if (busy_q) rk_q <= rk_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    for (int i = 0; i < 16; i++) rsp_o.block[8*i +: 8] = st_q[i];
  end

endmodule
`default_nettype wire

### hdl/acrd_mod_unit.sv
// Digit-serial remainder: restoring reduction of a byte, one quotient bit per cycle.
`default_nettype none
module acrd_mod_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] div_i,
  output logic            done_o,
  output logic [7:0]      rem_o,
  output logic            reject_o
);

  logic [8:0] rem_q, rem_d;
  logic [7:0] sh_q, sh_d;
  logic [7:0] div_q;
  logic [7:0] b_q;
  logic [3:0] cnt_q, cnt_d;
  logic       busy_q, busy_d, done_q, done_d;
  logic [8:0] trial;
  logic [9:0] next_mult;

  assign trial = {rem_q[7:0], sh_q[7]};

  always_comb begin
    rem_d = rem_q; sh_d = sh_q; cnt_d = cnt_q; busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      rem_d = '0; sh_d = byte_i; cnt_d = 4'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d = {sh_q[6:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; sh_q <= sh_d;
    if (start_i && !busy_q) begin
      div_q <= div_i;
      b_q   <= byte_i;
    end
  end

  // (q+1)*n = byte - rem + n; byte is at or past floor(256/n)*n iff this exceeds 256
  assign next_mult = {2'b00, b_q} - {2'b00, rem_q[7:0]} + {2'b00, div_q};
  assign done_o   = done_q;
  assign rem_o    = rem_q[7:0];
  assign reject_o = (next_mult > 10'd256);

endmodule
`default_nettype wire

### hdl/aes_counter_random_draw.sv
// Top level: draw sequencer with word, byte and bit buffers around the AES core.
// The AES core runs 10 rounds, one per cycle, for a draw that needs a new block; modular
// draws pass each byte through the remainder unit, and every rejected byte or word
// repeats the draw.
// One item in flight; the next is taken once the result has been handed off.
// rst_ni clears counter, buffers, indexes and keys asynchronously.
`default_nettype none
module aes_counter_random_draw #(
  parameter int unsigned PRIME       = 67,
  parameter int unsigned MAX_MODULUS = 63
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [2:0] cmd, [8:3] modulus
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [63:0] value
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_AES, S_BYTE, S_MODWAIT, S_MODCHK, S_OUT
  } state_e;

  localparam logic [8:0] PrimeBound = 9'((256 / PRIME) * PRIME);

  state_e      state_q;
  logic [2:0]  cmd_q;
  logic [7:0]  div_q;
  logic [8:0]  bound_q;
  logic [63:0] key_lo_q, key_hi_q;
  logic [31:0] ctr_q;
  logic [127:0] wblk_q, byblk_q, bitblk_q;
  logic        wnew_q;
  logic [3:0]  bidx_q;
  logic [6:0]  tidx_q;
  logic [1:0]  dst_q;   // 0 word, 1 byte, 2 bit
  logic [63:0] val_q;
  logic [7:0]  byte_q;
  logic        aes_go_q;
  logic        mod_go_q;

  acrd_pkg::aes_req_t req;
  acrd_pkg::aes_rsp_t rsp;
  logic       mdone, mrej;
  logic [7:0] mrem;
  logic [7:0] nin;

  assign req.start = aes_go_q;
  assign req.ctr   = ctr_q;

  acrd_aes_core u_aes (
    .clk_i, .rst_ni, .key_low_i(key_lo_q), .key_high_i(key_hi_q),
    .req_i(req), .rsp_o(rsp)
  );

  acrd_mod_unit u_mod (
    .clk_i, .rst_ni, .start_i(mod_go_q), .byte_i(byte_q), .div_i(div_q),
    .done_o(mdone), .rem_o(mrem), .reject_o(mrej)
  );

  assign nin = {2'b00, s_axis_tdata[8:3]};
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ctr_q <= '0; wblk_q <= '0; byblk_q <= '0; bitblk_q <= '0;
      wnew_q <= 1'b1; bidx_q <= '0; tidx_q <= '0; key_lo_q <= '0; key_hi_q <= '0;
      aes_go_q <= 1'b0; mod_go_q <= 1'b0; cmd_q <= '0; div_q <= '0; bound_q <= '0;
      dst_q <= '0; val_q <= '0; byte_q <= '0;
    end else begin
      aes_go_q <= 1'b0;
      mod_go_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          acrd_pkg::RegKeyLow:  key_lo_q <= cfg_data_i;
          acrd_pkg::RegKeyHigh: key_hi_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          cmd_q <= s_axis_tdata[2:0];
          if (s_axis_tdata[2:0] == acrd_pkg::CmdModN) begin
            // bound check for mod n is done by the remainder unit
            div_q   <= nin;
            bound_q <= 9'h100;
          end else begin
            div_q   <= 8'(PRIME);
            bound_q <= PrimeBound;
          end
          state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          val_q <= '0;
          priority if (cmd_q == acrd_pkg::CmdWord || cmd_q == acrd_pkg::CmdWordNot1) begin
            if (wnew_q) begin
              dst_q <= 2'd0; ctr_q <= ctr_q + 32'd1; aes_go_q <= 1'b1; state_q <= S_AES;
            end else begin
              val_q <= wblk_q[127:64]; wnew_q <= 1'b1;
              state_q <= (cmd_q == acrd_pkg::CmdWordNot1 && &wblk_q[127:64])
                         ? S_DISPATCH : S_OUT;
            end
          end else if (cmd_q == acrd_pkg::CmdBit) begin
            if (tidx_q == 7'd0) begin
              dst_q <= 2'd2; ctr_q <= ctr_q + 32'd1; aes_go_q <= 1'b1; state_q <= S_AES;
            end else begin
              val_q <= {63'd0, bitblk_q[tidx_q]}; tidx_q <= tidx_q + 7'd1; state_q <= S_OUT;
            end
          end else if (cmd_q == acrd_pkg::CmdByte || cmd_q == acrd_pkg::CmdPrime ||
                       cmd_q == acrd_pkg::CmdPrimeNz ||
                       (cmd_q == acrd_pkg::CmdModN && div_q != 8'd0 &&
                        div_q <= 8'(MAX_MODULUS))) begin
            if (bidx_q == 4'd0) begin
              dst_q <= 2'd1; ctr_q <= ctr_q + 32'd1; aes_go_q <= 1'b1; state_q <= S_AES;
            end else state_q <= S_BYTE;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_AES: if (rsp.done) begin
          unique case (dst_q)
            2'd0: begin
              wblk_q <= rsp.block; val_q <= rsp.block[63:0]; wnew_q <= 1'b0;
              state_q <= (cmd_q == acrd_pkg::CmdWordNot1 && &rsp.block[63:0])
                         ? S_DISPATCH : S_OUT;
            end
            2'd2: begin
              bitblk_q <= rsp.block; val_q <= {63'd0, rsp.block[0]};
              tidx_q <= 7'd1; state_q <= S_OUT;
            end
            default: begin byblk_q <= rsp.block; state_q <= S_BYTE; end
          endcase
        end
        S_BYTE: begin
          byte_q <= byblk_q[{bidx_q, 3'b000} +: 8];
          bidx_q <= bidx_q + 4'd1;
          if (cmd_q == acrd_pkg::CmdByte) begin
            val_q <= {56'd0, byblk_q[{bidx_q, 3'b000} +: 8]}; state_q <= S_OUT;
          end else if ({1'b0, byblk_q[{bidx_q, 3'b000} +: 8]} >= bound_q) begin
            state_q <= S_DISPATCH;
          end else begin
            mod_go_q <= 1'b1; state_q <= S_MODWAIT;
          end
        end
        S_MODWAIT: if (mdone) state_q <= mrej ? S_DISPATCH : S_MODCHK;
        S_MODCHK: begin
          val_q <= {56'd0, mrem};
          state_q <= (cmd_q == acrd_pkg::CmdPrimeNz && mrem == 8'd0) ? S_DISPATCH : S_OUT;
        end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_aes_ctr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aes_go_q |-> $past(ctr_q) + 32'd1 == ctr_q) else $error("counter not bumped");
  a_bidx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AES && dst_q == 2'd1) |-> bidx_q == 4'd0) else $error("byte fetch mid block");

endmodule
`default_nettype wire
